// ===== rtl/core/lsrm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsrm_pkg: shared types and constants of the light sensor read master
// Register codes, configuration and result structs, sequencer encodings and
// the fixed-point constants of the illuminance conversion.
// ----------------------------------------------------------------------------
package lsrm_pkg;

    // Configuration port geometry
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 20;

    // Register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_DEV_ADDR   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_PON_CMD    = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_MEAS_CMD   = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_WAIT_TICKS = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_ACK_POLLS  = 3'd4;

    // Register reset values
    localparam logic [6:0]  RST_DEV_ADDR   = 7'd35;
    localparam logic [7:0]  RST_PON_CMD    = 8'd1;
    localparam logic [7:0]  RST_MEAS_CMD   = 8'd35;
    localparam logic [19:0] RST_WAIT_TICKS = 20'd30000;
    localparam logic [7:0]  RST_ACK_POLLS  = 8'd250;

    // Field widths
    localparam int RAW_W = 16;
    localparam int LUX_W = 24;

    // lux = raw * 640 / 3 = raw * 213 + floor(raw / 3)
    // floor(raw / 3) = (raw * 43691) >> 17, exact for raw below 2^17
    localparam logic [7:0]  LUX_INT_MUL    = 8'd213;
    localparam logic [15:0] LUX_DIV3_MUL   = 16'd43691;
    localparam int          LUX_DIV3_SHIFT = 17;

    typedef struct packed {
        logic [6:0]  dev_addr;
        logic [7:0]  pon_cmd;
        logic [7:0]  meas_cmd;
        logic [19:0] wait_ticks;
        logic [7:0]  ack_polls;
    } t_cfg;

    // One result item
    typedef struct packed {
        logic             scl;
        logic             sda;
        logic             drv;
        logic             busy;
        logic             done;
        logic             err;
        logic [RAW_W-1:0] raw;
        logic [LUX_W-1:0] lux;
    } t_result;

    // Transaction steps of one measurement sequence
    typedef enum logic [3:0] {
        ST_IDLE       = 4'd0,
        ST_PON_START  = 4'd1,
        ST_PON_ADDR   = 4'd2,
        ST_PON_CMD    = 4'd3,
        ST_PON_STOP   = 4'd4,
        ST_MEAS_START = 4'd5,
        ST_MEAS_ADDR  = 4'd6,
        ST_MEAS_CMD   = 4'd7,
        ST_MEAS_STOP  = 4'd8,
        ST_WAIT       = 4'd9,
        ST_RD_START   = 4'd10,
        ST_RD_ADDR    = 4'd11,
        ST_RD_HI      = 4'd12,
        ST_RD_LO      = 4'd13,
        ST_RD_STOP    = 4'd14,
        ST_ERR_STOP   = 4'd15
    } t_step;

    // Bus phases within a step
    typedef enum logic [3:0] {
        PH_IDLE     = 4'd0,
        PH_START_A  = 4'd1,
        PH_START_B  = 4'd2,
        PH_TX_LOW   = 4'd3,
        PH_TX_HIGH  = 4'd4,
        PH_TX_TAIL  = 4'd5,
        PH_ACK_PREP = 4'd6,
        PH_ACK_POLL = 4'd7,
        PH_RD_LOW   = 4'd8,
        PH_RD_HIGH  = 4'd9,
        PH_MA_LOW   = 4'd10,
        PH_MA_HIGH  = 4'd11,
        PH_STOP_A   = 4'd12,
        PH_STOP_B   = 4'd13,
        PH_STOP_C   = 4'd14,
        PH_WAIT     = 4'd15
    } t_phase;

endpackage

// ===== rtl/core/lsrm_cfg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsrm_cfg: configuration register file
// Holds the five sequencer registers; writes to unknown indexes are dropped.
// ----------------------------------------------------------------------------
module lsrm_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [lsrm_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [lsrm_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    output lsrm_pkg::t_cfg                 o_cfg
);
    import lsrm_pkg::*;

    t_cfg r_cfg;

    // Register write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dev_addr   <= RST_DEV_ADDR;
            r_cfg.pon_cmd    <= RST_PON_CMD;
            r_cfg.meas_cmd   <= RST_MEAS_CMD;
            r_cfg.wait_ticks <= RST_WAIT_TICKS;
            r_cfg.ack_polls  <= RST_ACK_POLLS;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_DEV_ADDR:   r_cfg.dev_addr   <= i_cfg_wdata[6:0];
                CFG_PON_CMD:    r_cfg.pon_cmd    <= i_cfg_wdata[7:0];
                CFG_MEAS_CMD:   r_cfg.meas_cmd   <= i_cfg_wdata[7:0];
                CFG_WAIT_TICKS: r_cfg.wait_ticks <= i_cfg_wdata[19:0];
                CFG_ACK_POLLS:  r_cfg.ack_polls  <= i_cfg_wdata[7:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/core/lsrm_lux.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsrm_lux: raw count to illuminance
// lux_q8 = floor(raw * 640 / 3), built as raw * 213 plus raw / 3 by reciprocal.
// ----------------------------------------------------------------------------
module lsrm_lux (
    input  logic [lsrm_pkg::RAW_W-1:0] i_raw,
    output logic [lsrm_pkg::LUX_W-1:0] o_lux
);
    import lsrm_pkg::*;

    logic [LUX_W-1:0] int_part;
    logic [31:0]      div3_prod;
    logic [LUX_W-1:0] div3_part;

    // Integer multiple plus exact divide by three
    assign int_part  = LUX_W'(i_raw) * LUX_W'(LUX_INT_MUL);
    assign div3_prod = 32'(i_raw) * 32'(LUX_DIV3_MUL);
    assign div3_part = LUX_W'(div3_prod >> LUX_DIV3_SHIFT);
    assign o_lux     = int_part + div3_part;

endmodule

// ===== rtl/core/lsrm_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsrm_seq: bus sequencer
// Advances the I2C transaction state once per accepted tick item and
// forms the result item from the updated state.
// ----------------------------------------------------------------------------
module lsrm_seq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  logic              i_start,
    input  logic              i_sda,
    input  lsrm_pkg::t_cfg    i_cfg,
    output lsrm_pkg::t_result o_res
);
    import lsrm_pkg::*;

    typedef struct packed {
        t_step            step;
        t_phase           phase;
        logic [3:0]       bit_cnt;
        logic [19:0]      delay;
        logic [7:0]       poll;
        logic [7:0]       shift;
        logic [7:0]       high;
        logic [RAW_W-1:0] raw;
        logic [LUX_W-1:0] lux;
        logic             err;
        logic             scl;
        logic             sda;
        logic             drv;
    } t_seq_state;

    // Phase hold lengths, stored as length minus one
    localparam logic [19:0] HOLD_1 = 20'd0;
    localparam logic [19:0] HOLD_2 = 20'd1;
    localparam logic [19:0] HOLD_5 = 20'd4;
    localparam logic [19:0] HOLD_6 = 20'd5;

    t_seq_state       r_st;
    t_seq_state       n_st;
    logic [LUX_W-1:0] rd_lux;
    logic             done;

    // Enter a bus phase with its line levels and hold time
    function automatic t_seq_state f_enter(input t_seq_state s, input t_phase ph,
                                           input logic scl, input logic sda,
                                           input logic drv, input logic [19:0] hold);
        t_seq_state t;
        t       = s;
        t.phase = ph;
        t.scl   = scl;
        t.sda   = drv ? sda : 1'b1;
        t.drv   = drv;
        t.delay = hold;
        return t;
    endfunction

    // Start shifting out one byte, MSB first
    function automatic t_seq_state f_load(input t_seq_state s, input logic [7:0] b);
        t_seq_state t;
        t         = s;
        t.shift   = b;
        t.bit_cnt = 4'd0;
        t         = f_enter(t, PH_TX_LOW, 1'b0, b[7], 1'b1, HOLD_2);
        return t;
    endfunction

    // Open a transaction step
    function automatic t_seq_state f_begin(input t_seq_state s, input t_step stp,
                                           input t_cfg cfg);
        t_seq_state t;
        t      = s;
        t.step = stp;
        case (stp)
            ST_PON_START, ST_MEAS_START, ST_RD_START: begin
                t = f_enter(t, PH_START_A, 1'b1, 1'b1, 1'b1, HOLD_5);
            end
            ST_PON_ADDR, ST_MEAS_ADDR: t = f_load(t, {cfg.dev_addr, 1'b0});
            ST_PON_CMD:                t = f_load(t, cfg.pon_cmd);
            ST_MEAS_CMD:               t = f_load(t, cfg.meas_cmd);
            ST_RD_ADDR:                t = f_load(t, {cfg.dev_addr, 1'b1});
            ST_RD_HI, ST_RD_LO: begin
                t.shift   = 8'd0;
                t.bit_cnt = 4'd0;
                t         = f_enter(t, PH_RD_LOW, 1'b0, 1'b1, 1'b0, HOLD_2);
            end
            ST_WAIT: begin
                // zero wait goes straight into the read START
                if (cfg.wait_ticks == 20'd0) begin
                    t.step = ST_RD_START;
                    t      = f_enter(t, PH_START_A, 1'b1, 1'b1, 1'b1, HOLD_5);
                end else begin
                    t.phase = PH_WAIT;
                    t.scl   = 1'b1;
                    t.sda   = 1'b1;
                    t.drv   = 1'b1;
                    t.delay = cfg.wait_ticks - 20'd1;
                end
            end
            default: t = f_enter(t, PH_STOP_A, 1'b0, 1'b0, 1'b1, HOLD_1);
        endcase
        return t;
    endfunction

    // End of a step: next step, or close the sequence
    function automatic t_seq_state f_op_done(input t_seq_state s, input t_cfg cfg,
                                             input logic [LUX_W-1:0] lux);
        t_seq_state t;
        t = s;
        if (s.step == ST_RD_HI) begin
            t.high = s.shift;
        end
        if (s.step == ST_RD_STOP || s.step == ST_ERR_STOP) begin
            if (s.step == ST_RD_STOP) begin
                t.raw = {s.high, s.shift};
                t.lux = lux;
            end
            t.step  = ST_IDLE;
            t.phase = PH_IDLE;
            t.scl   = 1'b1;
            t.sda   = 1'b1;
            t.drv   = 1'b1;
            t.delay = 20'd0;
        end else begin
            t = f_begin(t, t_step'(s.step + 4'd1), cfg);
        end
        return t;
    endfunction

    // Illuminance of the byte pair being closed by the read STOP
    lsrm_lux u_lux (
        .i_raw (RAW_W'({r_st.high, r_st.shift})),
        .o_lux (rd_lux)
    );

    // Next state for one tick
    always_comb begin
        n_st = r_st;
        if (r_st.step == ST_IDLE) begin
            if (i_start) begin
                n_st.err = 1'b0;
                n_st     = f_begin(n_st, ST_PON_START, i_cfg);
            end
        end else if (r_st.delay != 20'd0) begin
            n_st.delay = r_st.delay - 20'd1;
        end else begin
            case (r_st.phase)
                PH_START_A: n_st = f_enter(r_st, PH_START_B, 1'b1, 1'b0, 1'b1, HOLD_6);
                PH_START_B: n_st = f_op_done(r_st, i_cfg, rd_lux);
                PH_TX_LOW:  n_st = f_enter(r_st, PH_TX_HIGH, 1'b1, r_st.sda, 1'b1, HOLD_2);
                PH_TX_HIGH: begin
                    n_st.shift   = {r_st.shift[6:0], 1'b0};
                    n_st.bit_cnt = r_st.bit_cnt + 4'd1;
                    n_st = f_enter(n_st, PH_TX_TAIL, 1'b0, r_st.sda, 1'b1, HOLD_2);
                end
                PH_TX_TAIL: begin
                    if (r_st.bit_cnt >= 4'd8) begin
                        n_st = f_enter(r_st, PH_ACK_PREP, 1'b0, 1'b1, 1'b1, HOLD_1);
                    end else begin
                        n_st = f_enter(r_st, PH_TX_LOW, 1'b0, r_st.shift[7], 1'b1, HOLD_2);
                    end
                end
                PH_ACK_PREP: begin
                    n_st.poll = 8'd0;
                    n_st = f_enter(n_st, PH_ACK_POLL, 1'b1, 1'b1, 1'b0, HOLD_1);
                end
                PH_ACK_POLL: begin
                    // low sample is the ack; too many high polls is a timeout
                    if (!i_sda) begin
                        n_st = f_op_done(r_st, i_cfg, rd_lux);
                    end else if (r_st.poll >= i_cfg.ack_polls) begin
                        n_st.err = 1'b1;
                        n_st     = f_begin(n_st, ST_ERR_STOP, i_cfg);
                    end else begin
                        n_st.poll = r_st.poll + 8'd1;
                    end
                end
                PH_RD_LOW:  n_st = f_enter(r_st, PH_RD_HIGH, 1'b1, 1'b1, 1'b0, HOLD_1);
                PH_RD_HIGH: begin
                    n_st.shift   = {r_st.shift[6:0], i_sda};
                    n_st.bit_cnt = r_st.bit_cnt + 4'd1;
                    if (r_st.bit_cnt >= 4'd7) begin
                        // ack the high byte, nack the low byte
                        n_st = f_enter(n_st, PH_MA_LOW, 1'b0, r_st.step == ST_RD_LO,
                                       1'b1, HOLD_2);
                    end else begin
                        n_st = f_enter(n_st, PH_RD_LOW, 1'b0, 1'b1, 1'b0, HOLD_2);
                    end
                end
                PH_MA_LOW:  n_st = f_enter(r_st, PH_MA_HIGH, 1'b1, r_st.sda, 1'b1, HOLD_5);
                PH_MA_HIGH: n_st = f_op_done(r_st, i_cfg, rd_lux);
                PH_STOP_A:  n_st = f_enter(r_st, PH_STOP_B, 1'b1, 1'b0, 1'b1, HOLD_6);
                PH_STOP_B:  n_st = f_enter(r_st, PH_STOP_C, 1'b1, 1'b1, 1'b1, HOLD_6);
                PH_STOP_C:  n_st = f_op_done(r_st, i_cfg, rd_lux);
                PH_WAIT:    n_st = f_begin(r_st, ST_RD_START, i_cfg);
                default: begin
                    n_st.step  = ST_IDLE;
                    n_st.phase = PH_IDLE;
                    n_st.scl   = 1'b1;
                    n_st.sda   = 1'b1;
                    n_st.drv   = 1'b1;
                end
            endcase
        end
    end

    // Sequence end: a running step closed through its final phase
    assign done = (r_st.step != ST_IDLE) && (r_st.phase != PH_IDLE) &&
                  (r_st.delay == 20'd0) && (n_st.step == ST_IDLE);

    // State register, advanced once per accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st.step    <= ST_IDLE;
            r_st.phase   <= PH_IDLE;
            r_st.bit_cnt <= 4'd0;
            r_st.delay   <= 20'd0;
            r_st.poll    <= 8'd0;
            r_st.shift   <= 8'd0;
            r_st.high    <= 8'd0;
            r_st.raw     <= '0;
            r_st.lux     <= '0;
            r_st.err     <= 1'b0;
            r_st.scl     <= 1'b1;
            r_st.sda     <= 1'b1;
            r_st.drv     <= 1'b1;
        end else if (i_load) begin
            r_st <= n_st;
        end
    end

    // Result item from the updated state
    always_comb begin
        o_res.scl  = n_st.scl;
        o_res.sda  = n_st.sda;
        o_res.drv  = n_st.drv;
        o_res.busy = (n_st.step != ST_IDLE);
        o_res.done = done;
        o_res.err  = n_st.err;
        o_res.raw  = n_st.raw;
        o_res.lux  = n_st.lux;
    end

endmodule

// ===== rtl/core/lsrm_out.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsrm_out: result register
// Holds one result item; takes a new one in the cycle the old one is taken.
// ----------------------------------------------------------------------------
module lsrm_out (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  lsrm_pkg::t_result i_res,
    input  logic              i_m_tready,
    output logic              o_ready,
    output logic              o_valid,
    output lsrm_pkg::t_result o_res
);
    import lsrm_pkg::*;

    logic    r_valid;
    t_result r_res;

    // Room when empty or when the held item leaves this cycle
    assign o_ready = !r_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_valid <= 1'b0;
        end
    end

    // Payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

// ===== rtl/core/i2c_light_sensor_read_master_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_light_sensor_read_master_top: light sensor read master
// Tick-driven I2C master: power-on write, measure write, conversion wait and
// a two-byte read, with raw count and Q8 illuminance on every result item.
// ----------------------------------------------------------------------------
//  Channel  Direction  Carries
//  s        in         tick item: start request, sampled SDA
//  m        out        result item: line levels, status, raw count, lux
//  cfg      in         register writes, index and data, no read-back
//
//  One item per cycle unless m stalls: each accepted tick is one sequencer
//  update, computed in the same cycle and held in the result register.
//  The single result register sets the stall behavior: s is ready whenever it
//  is empty or its item is taken in that cycle.
//  Reset is synchronous, active low; the block is idle with SCL and SDA high.
// ----------------------------------------------------------------------------
module i2c_light_sensor_read_master_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // tick items
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [7:0]                      i_s_tdata,  // [0] start_request, [1] sda_sample
    // result items
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [47:0]                     o_m_tdata,  // [0] scl_level, [1] sda_level,
                                                        // [2] sda_driving, [3] busy_res,
                                                        // [4] ack_error, [20:5] raw_count,
                                                        // [44:21] lux_q8
    output logic                            o_m_tlast,  // done_res
    // configuration
    input  logic                            i_cfg_we,
    input  logic [lsrm_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [lsrm_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);
    import lsrm_pkg::*;

    t_cfg    cfg;
    t_result seq_res;
    t_result out_res;
    logic    accept;

    assign accept = i_s_tvalid && o_s_tready;

    // Register file
    lsrm_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    // Sequencer
    lsrm_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (accept),
        .i_start (i_s_tdata[0]),
        .i_sda   (i_s_tdata[1]),
        .i_cfg   (cfg),
        .o_res   (seq_res)
    );

    // Result register
    lsrm_out u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (accept),
        .i_res      (seq_res),
        .i_m_tready (i_m_tready),
        .o_ready    (o_s_tready),
        .o_valid    (o_m_tvalid),
        .o_res      (out_res)
    );

    // Pack result fields
    assign o_m_tdata = {3'd0, out_res.lux, out_res.raw, out_res.err, out_res.busy,
                        out_res.drv, out_res.sda, out_res.scl};
    assign o_m_tlast = out_res.done;

    // An accepted tick always leaves a result item behind
    a_accept_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_m_tvalid)
        else $error("accepted tick produced no result item");

    // A sequence end never reports busy
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tlast) |-> !o_m_tdata[3])
        else $error("done pulse while still busy");

    // Released SDA reads as high
    a_released_sda_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tdata[2]) |-> o_m_tdata[1])
        else $error("sda level low while released");

    // Raw count only changes on a sequence end
    a_raw_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (seq_res.raw != $past(seq_res.raw)) && $past(accept))
            |-> seq_res.done)
        else $error("raw count changed outside a sequence end");

endmodule
